/* rtl/core/bpd_pkg.sv */
// Blank page detector package: shared types, register and mode codes,
// and the nibble popcount table.
// No dependencies.
package bpd_pkg;

    localparam int CountW = 32;
    localparam int HitW   = 4;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    typedef logic [CountW-1:0] t_count;
    typedef logic [HitW-1:0]   t_hits;
    typedef logic [AddrW-1:0]  t_addr;
    typedef logic [DataW-1:0]  t_data;
    typedef logic [2:0]        t_reg_idx;

    localparam logic [1:0] MODE_BIT  = 2'd0;
    localparam logic [1:0] MODE_GREY = 2'd1;
    localparam logic [1:0] MODE_RGB  = 2'd2;

    localparam logic [1:0] POLICY_RECORD = 2'd0;
    localparam logic [1:0] POLICY_MARK   = 2'd1;
    localparam logic [1:0] POLICY_BACK   = 2'd2;

    localparam t_reg_idx REG_DEPTH_MODE   = 3'd0;
    localparam t_reg_idx REG_PIXEL_TARGET = 3'd1;
    localparam t_reg_idx REG_BLANK_POLICY = 3'd2;
    localparam t_reg_idx REG_GREY_LIMIT   = 3'd3;
    localparam t_reg_idx REG_RGB_LIMIT    = 3'd4;

    localparam logic [1:0] DEPTH_MODE_RST   = MODE_GREY;
    localparam t_count     PIXEL_TARGET_RST = '0;
    localparam logic [1:0] BLANK_POLICY_RST = POLICY_RECORD;
    localparam logic [7:0] GREY_LIMIT_RST   = 8'd251;
    localparam logic [7:0] RGB_LIMIT_RST    = 8'd240;

    localparam t_hits PIX_PER_BIT_BYTE = 4'd8;
    localparam t_hits PIX_PER_PIXEL    = 4'd1;

    typedef struct packed {
        logic [1:0] depth_mode;
        t_count     pixel_target;
        logic [1:0] blank_policy;
        logic [7:0] grey_limit;
        logic [7:0] rgb_limit;
    } t_cfg;

    function automatic logic [2:0] nibble_ones(input logic [3:0] nib);
        logic [2:0] ones;
        case (nib)
            4'h0: ones = 3'd0;
            4'h1, 4'h2, 4'h4, 4'h8: ones = 3'd1;
            4'h3, 4'h5, 4'h6, 4'h9, 4'ha, 4'hc: ones = 3'd2;
            4'h7, 4'hb, 4'hd, 4'he: ones = 3'd3;
            default: ones = 3'd4;
        endcase
        return ones;
    endfunction

endpackage

/* rtl/core/bpd_in_if.sv */
// Input channel of the blank page detector: one raster word per beat.
// Depends on nothing.
interface bpd_in_if;
    logic       valid;
    logic       ready;
    logic       first_of_page;
    logic       end_of_page;
    logic       front_side;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;

    modport source (output valid, first_of_page, end_of_page, front_side,
                    byte_a, byte_b, byte_c, input ready);
    modport sink   (input valid, first_of_page, end_of_page, front_side,
                    byte_a, byte_b, byte_c, output ready);
endinterface

/* rtl/core/bpd_out_if.sv */
// Result channel of the blank page detector: one count result per beat.
// Depends on nothing.
interface bpd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] nonblank_total;
    logic [31:0] pixel_total;
    logic        still_blank;
    logic        blank_flag;
    logic        page_done;

    modport source (output valid, nonblank_total, pixel_total, still_blank,
                    blank_flag, page_done, input ready);
    modport sink   (input valid, nonblank_total, pixel_total, still_blank,
                    blank_flag, page_done, output ready);
endinterface

/* rtl/core/bpd_cfg_regs.sv */
// APB-style configuration registers of the blank page detector.
// Depends on bpd_pkg.
module bpd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  bpd_pkg::t_addr paddr,
    input  bpd_pkg::t_data pwdata,
    output bpd_pkg::t_data prdata,
    output logic           pready,
    output bpd_pkg::t_cfg  o_cfg
);

    bpd_pkg::t_cfg    r_cfg;
    bpd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode   <= bpd_pkg::DEPTH_MODE_RST;
            r_cfg.pixel_target <= bpd_pkg::PIXEL_TARGET_RST;
            r_cfg.blank_policy <= bpd_pkg::BLANK_POLICY_RST;
            r_cfg.grey_limit   <= bpd_pkg::GREY_LIMIT_RST;
            r_cfg.rgb_limit    <= bpd_pkg::RGB_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                bpd_pkg::REG_DEPTH_MODE:   r_cfg.depth_mode   <= pwdata[1:0];
                bpd_pkg::REG_PIXEL_TARGET: r_cfg.pixel_target <= pwdata;
                bpd_pkg::REG_BLANK_POLICY: r_cfg.blank_policy <= pwdata[1:0];
                bpd_pkg::REG_GREY_LIMIT:   r_cfg.grey_limit   <= pwdata[7:0];
                bpd_pkg::REG_RGB_LIMIT:    r_cfg.rgb_limit    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bpd_pkg::REG_DEPTH_MODE:   prdata = {30'd0, r_cfg.depth_mode};
            bpd_pkg::REG_PIXEL_TARGET: prdata = r_cfg.pixel_target;
            bpd_pkg::REG_BLANK_POLICY: prdata = {30'd0, r_cfg.blank_policy};
            bpd_pkg::REG_GREY_LIMIT:   prdata = {24'd0, r_cfg.grey_limit};
            bpd_pkg::REG_RGB_LIMIT:    prdata = {24'd0, r_cfg.rgb_limit};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/bpd_classify.sv */
// Pixel classifier: non-blank hits and pixel count of one raster word.
// Depends on bpd_pkg.
module bpd_classify (
    input  bpd_pkg::t_cfg  i_cfg,
    input  logic [7:0]     i_byte_a,
    input  logic [7:0]     i_byte_b,
    input  logic [7:0]     i_byte_c,
    output bpd_pkg::t_hits o_hits,
    output bpd_pkg::t_hits o_pix
);

    logic [2:0] w_ones_lo;
    logic [2:0] w_ones_hi;
    logic       w_grey_hit;
    logic       w_rgb_hit;

    assign w_ones_lo  = bpd_pkg::nibble_ones(i_byte_a[3:0]);
    assign w_ones_hi  = bpd_pkg::nibble_ones(i_byte_a[7:4]);
    assign w_grey_hit = i_byte_a < i_cfg.grey_limit;
    assign w_rgb_hit  = (i_byte_a < i_cfg.rgb_limit) ||
                        (i_byte_b < i_cfg.rgb_limit) ||
                        (i_byte_c < i_cfg.rgb_limit);

    always_comb begin
        case (i_cfg.depth_mode)
            bpd_pkg::MODE_BIT: begin
                o_hits = {1'b0, w_ones_lo} + {1'b0, w_ones_hi};
                o_pix  = bpd_pkg::PIX_PER_BIT_BYTE;
            end
            bpd_pkg::MODE_GREY: begin
                o_hits = {3'd0, w_grey_hit};
                o_pix  = bpd_pkg::PIX_PER_PIXEL;
            end
            bpd_pkg::MODE_RGB: begin
                o_hits = {3'd0, w_rgb_hit};
                o_pix  = bpd_pkg::PIX_PER_PIXEL;
            end
            default: begin
                o_hits = '0;
                o_pix  = '0;
            end
        endcase
    end

endmodule

/* rtl/core/blank_page_detector.sv */
// Blank page detector top level: input register, classifier, saturating
// page counters and result register. Depends on bpd_pkg, bpd_in_if,
// bpd_out_if, bpd_cfg_regs and bpd_classify.
//
//  channel  | dir | handshake        | beat
//  ---------+-----+------------------+------------------------------------------
//  i_in     | in  | valid/ready      | page flags and three pixel bytes
//  o_res    | out | valid/ready      | counts, still_blank, blank_flag, page_done
//  APB      | in  | psel/penable     | register write or read, pready always high
//
// One beat per cycle sustained while o_res is not stalled; a beat's result
// reaches o_res through the input register, then the result register, and
// can be taken there while o_res.ready is high.
// Synchronous active-low reset clears both counters and all valid flags and
// loads the register defaults.
// A stall on o_res holds the result; an empty input register still takes one more
// beat before i_in.ready drops.
module blank_page_detector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bpd_in_if.sink         i_in,
    bpd_out_if.source      o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  bpd_pkg::t_addr paddr,
    input  bpd_pkg::t_data pwdata,
    output bpd_pkg::t_data prdata,
    output logic           pready
);

    bpd_pkg::t_cfg   w_cfg;

    logic            r_s1_valid;
    logic            r_s1_first;
    logic            r_s1_last;
    logic            r_s1_front;
    logic [7:0]      r_s1_a;
    logic [7:0]      r_s1_b;
    logic [7:0]      r_s1_c;

    logic            r_o_valid;
    bpd_pkg::t_count r_nb_count;
    bpd_pkg::t_count r_px_count;
    logic            r_still;
    logic            r_mark;
    logic            r_done;

    bpd_pkg::t_hits  w_hits;
    bpd_pkg::t_hits  w_pix;
    bpd_pkg::t_count w_nb_base;
    bpd_pkg::t_count w_px_base;
    logic [32:0]     w_nb_sum;
    logic [32:0]     w_px_sum;
    bpd_pkg::t_count n_nb_count;
    bpd_pkg::t_count n_px_count;
    logic            n_still;
    logic            n_mark;
    logic            w_in_acc;
    logic            w_s1_adv;

    bpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bpd_classify u_classify (
        .i_cfg    (w_cfg),
        .i_byte_a (r_s1_a),
        .i_byte_b (r_s1_b),
        .i_byte_c (r_s1_c),
        .o_hits   (w_hits),
        .o_pix    (w_pix)
    );

    assign w_s1_adv   = r_s1_valid && (!r_o_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_nb_base  = r_s1_first ? '0 : r_nb_count;
    assign w_px_base  = r_s1_first ? '0 : r_px_count;
    assign w_nb_sum   = {1'b0, w_nb_base} + {29'd0, w_hits};
    assign w_px_sum   = {1'b0, w_px_base} + {29'd0, w_pix};
    assign n_nb_count = w_nb_sum[32] ? '1 : w_nb_sum[31:0];
    assign n_px_count = w_px_sum[32] ? '1 : w_px_sum[31:0];
    assign n_still    = n_nb_count < w_cfg.pixel_target;

    always_comb begin
        n_mark = 1'b0;
        if (r_s1_last && n_still) begin
            case (w_cfg.blank_policy)
                bpd_pkg::POLICY_MARK: n_mark = 1'b1;
                bpd_pkg::POLICY_BACK: n_mark = !r_s1_front;
                default:              n_mark = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_nb_count <= '0;
            r_px_count <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_valid  <= 1'b1;
                r_nb_count <= n_nb_count;
                r_px_count <= n_px_count;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_first <= i_in.first_of_page;
            r_s1_last  <= i_in.end_of_page;
            r_s1_front <= i_in.front_side;
            r_s1_a     <= i_in.byte_a;
            r_s1_b     <= i_in.byte_b;
            r_s1_c     <= i_in.byte_c;
        end
        if (w_s1_adv) begin
            r_still <= n_still;
            r_mark  <= n_mark;
            r_done  <= r_s1_last;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.nonblank_total = r_nb_count;
    assign o_res.pixel_total    = r_px_count;
    assign o_res.still_blank    = r_still;
    assign o_res.blank_flag     = r_mark;
    assign o_res.page_done      = r_done;

    a_mark_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.blank_flag |-> o_res.page_done && o_res.still_blank)
        else $error("blank flag without end of page or while not blank");

    a_pixels_cover_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.pixel_total >= o_res.nonblank_total)
        else $error("non-blank count exceeds pixel count");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid && i_in.ready)
        else $error("pipeline not empty after reset");

    a_stall_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_nb_count) && $stable(r_px_count))
        else $error("counters moved while result stalled");

endmodule
